@@ src/rpba_pkg.sv @@
// Shared constants and types of the rotating priority bank arbiter.
package rpba_pkg;

	localparam int PROCS      = 16;
	localparam int PROC_W     = $clog2(PROCS);
	localparam int BANK_W     = 8;
	localparam int CNT_W      = 9;
	localparam int WAIT_W     = 32;
	localparam int FIFO_DEPTH = 2;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [CNT_W-1:0] BANK_COUNT_RST = CNT_W'(256);

	// Operation codes of an input transaction
	localparam logic OP_POST = 1'b0;
	localparam logic OP_RUN  = 1'b1;

	typedef struct packed {
		logic              op;
		logic [PROC_W-1:0] proc;
		logic [BANK_W-1:0] bank;
	} cmd_t;

	typedef struct packed {
		logic [PROC_W-1:0] proc_id;
		logic              granted;
		logic              waiting;
		logic [WAIT_W-1:0] wait_total;
		logic [PROC_W-1:0] next_start;
		logic              last;
	} result_t;

endpackage

@@ src/rpba_intf.sv @@
// Valid/ready channel interfaces for input and result transactions.
interface rpba_in_if import rpba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [PROC_W-1:0] processor;
	logic [BANK_W-1:0] bank;

	modport source (output valid, operation, processor, bank, input ready);
	modport sink   (input valid, operation, processor, bank, output ready);
endinterface

interface rpba_out_if import rpba_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PROC_W-1:0] proc_id;
	logic              granted;
	logic              waiting;
	logic [WAIT_W-1:0] wait_total;
	logic [PROC_W-1:0] next_start;
	logic              last;

	modport source (output valid, proc_id, granted, waiting, wait_total, next_start, last,
		input ready);
	modport sink   (input valid, proc_id, granted, waiting, wait_total, next_start, last,
		output ready);
endinterface

@@ src/rpba_front.sv @@
// Front stage: holds bank_count, accepts input transactions and drops out-of-range posts.
module rpba_front import rpba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	rpba_in_if.sink          in_ch,
	output cmd_t             cmd,
	output logic             cmd_valid,
	input  logic             cmd_ready
);

	logic [CNT_W-1:0] bank_count_q;
	logic             valid_s1;
	cmd_t             cmd_s1;
	logic             keep;
	logic             accept;

	assign accept      = in_ch.valid && in_ch.ready;
	assign in_ch.ready = !valid_s1 || cmd_ready;
	assign keep        = (in_ch.operation == OP_RUN) || ({1'b0, in_ch.bank} < bank_count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_count_q <= BANK_COUNT_RST;
			valid_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				bank_count_q <= cfg_wdata;
			end
			if (accept) begin
				valid_s1 <= keep;
			end else if (cmd_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.op   <= in_ch.operation;
			cmd_s1.proc <= in_ch.processor;
			cmd_s1.bank <= in_ch.bank;
		end
	end

	assign cmd       = cmd_s1;
	assign cmd_valid = valid_s1;

endmodule

@@ src/rpba_cmd_fifo.sv @@
// Short command queue between the front and the arbitration engine.
module rpba_cmd_fifo import rpba_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  cmd_t wr_data,
	input  logic wr_valid,
	output logic wr_ready,
	output cmd_t rd_data,
	output logic rd_valid,
	input  logic rd_ready
);

	cmd_t                  mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;
	logic                  push;
	logic                  pop;

	assign wr_ready = count_q != FIFO_CNT_W'(FIFO_DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ src/rpba_back.sv @@
// Arbitration engine: request table, rotating walk, result emission and output register.
module rpba_back import rpba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	rpba_out_if.source out_ch
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_EMIT = 3'b100
	} eng_state_t;

	eng_state_t        state_q;
	logic [PROCS-1:0]  req_valid_q;
	logic [BANK_W-1:0] req_bank_q [PROCS];
	logic [WAIT_W-1:0] blocked_q [PROCS];
	logic [PROCS-1:0]  grant_q;
	logic [PROC_W-1:0] cursor_q;
	logic [PROC_W-1:0] step_q;
	logic [PROC_W-1:0] start_q;
	result_t           res_q;
	logic              out_valid_q;

	logic [BANK_W-1:0] cur_bank;
	logic [WAIT_W-1:0] cur_wait;
	logic [WAIT_W-1:0] wait_inc;
	logic              busy;
	logic [PROC_W-1:0] next_start;
	logic [PROC_W-1:0] cursor_nxt;
	logic              step_last;
	logic              out_free;
	logic              post_take;

	assign cur_bank   = req_bank_q[cursor_q];
	assign cur_wait   = blocked_q[cursor_q];
	assign wait_inc   = (cur_wait == '1) ? cur_wait : cur_wait + 1'b1;
	assign cursor_nxt = (cursor_q == PROC_W'(PROCS - 1)) ? '0 : cursor_q + 1'b1;
	assign step_last  = step_q == PROC_W'(PROCS - 1);
	assign out_free   = !out_valid_q || out_ch.ready;
	assign cmd_ready  = state_q == ST_IDLE;
	assign post_take  = cmd_ready && cmd_valid && (cmd.op == OP_POST) && !req_valid_q[cmd.proc];

	// A bank is busy when a processor already granted in this run asked for it
	always_comb begin
		busy = 1'b0;
		for (int j = 0; j < PROCS; j++) begin
			if (grant_q[j] && (req_bank_q[j] == cur_bank)) begin
				busy = 1'b1;
			end
		end
	end

	// Lowest-numbered processor still waiting
	always_comb begin
		next_start = '0;
		for (int k = PROCS - 1; k >= 0; k--) begin
			if (req_valid_q[k]) begin
				next_start = PROC_W'(k);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_valid_q <= '0;
			grant_q     <= '0;
			cursor_q    <= '0;
			step_q      <= '0;
			start_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < PROCS; i++) begin
				blocked_q[i] <= '0;
			end
		end else begin
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (post_take) begin
						req_valid_q[cmd.proc] <= 1'b1;
					end
					if (cmd_valid && (cmd.op == OP_RUN)) begin
						grant_q  <= '0;
						cursor_q <= start_q;
						step_q   <= '0;
						state_q  <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (req_valid_q[cursor_q]) begin
						if (!busy) begin
							grant_q[cursor_q]     <= 1'b1;
							req_valid_q[cursor_q] <= 1'b0;
						end else begin
							blocked_q[cursor_q] <= wait_inc;
						end
					end
					cursor_q <= cursor_nxt;
					step_q   <= step_q + 1'b1;
					if (step_last) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						cursor_q <= cursor_nxt;
						step_q   <= step_q + 1'b1;
						if (step_last) begin
							start_q <= next_start;
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (post_take) begin
			req_bank_q[cmd.proc] <= cmd.bank;
		end
		if ((state_q == ST_EMIT) && out_free) begin
			res_q.proc_id    <= cursor_q;
			res_q.granted    <= grant_q[cursor_q];
			res_q.waiting    <= req_valid_q[cursor_q];
			res_q.wait_total <= cur_wait;
			res_q.next_start <= next_start;
			res_q.last       <= step_last;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.proc_id    = res_q.proc_id;
	assign out_ch.granted    = res_q.granted;
	assign out_ch.waiting    = res_q.waiting;
	assign out_ch.wait_total = res_q.wait_total;
	assign out_ch.next_start = res_q.next_start;
	assign out_ch.last       = res_q.last;

endmodule

@@ src/rotating_priority_bank_arbiter_top.sv @@
// Top level of the rotating priority memory-bank arbiter.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+-------------------------------------------------
//  in_ch    | in  | valid/ready         | operation, processor, bank
//  out_ch   | out | valid/ready         | proc_id, granted, waiting, wait_total,
//           |     |                     | next_start, last
//  cfg      | in  | cfg_we (no ready)   | cfg_wdata = bank_count
//
// A post is stored by the engine while it is idle. A run starts from idle, walks the request
// table one processor per cycle in rotating order from the start pointer, and then emits one
// result per processor. arst_n clears all pending requests, the wait counters and the start
// pointer, and sets bank_count to 256. The front stage and the two-entry command queue keep
// taking transactions while the engine is busy, until the queue fills; a stalled result sink
// holds the emit phase in place.
module rotating_priority_bank_arbiter_top import rpba_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	rpba_in_if.sink          in_ch,
	rpba_out_if.source       out_ch
);

	// front -> queue
	cmd_t front_cmd;
	logic front_valid;
	logic front_ready;

	// queue -> engine
	cmd_t eng_cmd;
	logic eng_valid;
	logic eng_ready;

	// Accept transactions, hold bank_count, drop posts to banks out of range
	rpba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	// Decouple the front from the engine so each side stalls on its own
	rpba_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (front_cmd),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_data  (eng_cmd),
		.rd_valid (eng_valid),
		.rd_ready (eng_ready)
	);

	// Store requests, walk processors in rotating order, emit one result per processor
	rpba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (eng_cmd),
		.cmd_valid (eng_valid),
		.cmd_ready (eng_ready),
		.out_ch    (out_ch)
	);

endmodule
